// File: hdl/rmq_pkg.sv
`default_nettype none

package rmq_pkg;

  localparam int ELEM_W        = 16;
  localparam int FRAC_BITS_DEF = 14;
  localparam int NUM_COMP      = 4;

  typedef logic signed [ELEM_W-1:0] elem_t;

endpackage

`default_nettype wire

// File: hdl/rotation_matrix_to_quaternion_unit.sv
// Channel   Ports                                   Handshake
// -------   -------------------------------------   ---------------------------------
// input     start, busy, in_elem_r0c0..r2c2         transaction when start && !busy
// result    out_valid, out_quat_w/x/y/z,            one-cycle strobe, cannot be held
//           out_bad_input
//
// One transaction per cycle while busy is low. The latency is set by the
// bit-per-stage square root (half the radicand width) and the bit-per-stage
// divider (FRAC_BITS + 1 stages, at most 16).
// busy is high only while rst_n is low; synchronous reset flushes all valid bits.
// The result side has no backpressure, so the pipeline never stalls.
`default_nettype none

module rotation_matrix_to_quaternion_unit #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  rmq_pkg::elem_t in_elem_r0c0,
  input  rmq_pkg::elem_t in_elem_r0c1,
  input  rmq_pkg::elem_t in_elem_r0c2,
  input  rmq_pkg::elem_t in_elem_r1c0,
  input  rmq_pkg::elem_t in_elem_r1c1,
  input  rmq_pkg::elem_t in_elem_r1c2,
  input  rmq_pkg::elem_t in_elem_r2c0,
  input  rmq_pkg::elem_t in_elem_r2c1,
  input  rmq_pkg::elem_t in_elem_r2c2,
  output logic           out_valid,
  output rmq_pkg::elem_t out_quat_w,
  output rmq_pkg::elem_t out_quat_x,
  output rmq_pkg::elem_t out_quat_y,
  output rmq_pkg::elem_t out_quat_z,
  output logic           out_bad_input
);

  import rmq_pkg::*;

  localparam int TW     = ((FRAC_BITS > ELEM_W - 1) ? FRAC_BITS : ELEM_W - 1) + 3;
  localparam int MW     = TW - 1;
  localparam int RW     = MW + FRAC_BITS;
  localparam int RAD_W  = RW + (RW % 2);
  localparam int ROOT_W = RAD_W / 2;
  localparam int QW     = ((FRAC_BITS < ELEM_W - 1) ? FRAC_BITS : ELEM_W - 1) + 1;
  localparam int LAT    = 3 + ROOT_W + 2 + QW + 1;

  typedef logic signed [TW-1:0] wide_t;

  localparam wide_t ONE_T = wide_t'(1) << FRAC_BITS;

  typedef struct packed {
    logic                          bad;
    logic [NUM_COMP-1:0]           neg;
    logic [NUM_COMP-1:0][MW-1:0]   mag;
  } side_t;

  logic                    acc;
  logic                    s0_valid_r;
  elem_t [8:0]             s0_m_r;

  wide_t                   w00, w01, w02, w10, w11, w12, w20, w21, w22;
  wide_t                   s1_t_nxt;
  wide_t [NUM_COMP-1:0]    s1_comp_nxt;
  logic                    s1_valid_r;
  wide_t                   s1_t_r;
  wide_t [NUM_COMP-1:0]    s1_comp_r;

  side_t                   s2_side_nxt;
  logic [RAD_W-1:0]        s2_rad_nxt;
  logic                    s2_valid_r;
  side_t                   s2_side_r;
  logic [RAD_W-1:0]        s2_rad_r;

  logic                    sq_valid;
  logic [ROOT_W-1:0]       sq_root;
  logic [$bits(side_t)-1:0] sq_side_bits;
  side_t                   sq_side;
  elem_t [NUM_COMP-1:0]    quat;

  assign busy = ~rst_n;
  assign acc  = start && !busy;

  always_ff @(posedge clk) begin
    s0_m_r     <= {in_elem_r2c2, in_elem_r2c1, in_elem_r2c0,
                   in_elem_r1c2, in_elem_r1c1, in_elem_r1c0,
                   in_elem_r0c2, in_elem_r0c1, in_elem_r0c0};
    s0_valid_r <= acc;
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end
  end

  always_comb begin
    w00 = wide_t'(s0_m_r[0]);
    w01 = wide_t'(s0_m_r[1]);
    w02 = wide_t'(s0_m_r[2]);
    w10 = wide_t'(s0_m_r[3]);
    w11 = wide_t'(s0_m_r[4]);
    w12 = wide_t'(s0_m_r[5]);
    w20 = wide_t'(s0_m_r[6]);
    w21 = wide_t'(s0_m_r[7]);
    w22 = wide_t'(s0_m_r[8]);
    if (w22 < 0) begin
      if (w00 > w11) begin
        s1_t_nxt       = ONE_T + w00 - w11 - w22;
        s1_comp_nxt[0] = w12 - w21;
        s1_comp_nxt[1] = s1_t_nxt;
        s1_comp_nxt[2] = w01 + w10;
        s1_comp_nxt[3] = w20 + w02;
      end else begin
        s1_t_nxt       = ONE_T - w00 + w11 - w22;
        s1_comp_nxt[0] = w20 - w02;
        s1_comp_nxt[1] = w01 + w10;
        s1_comp_nxt[2] = s1_t_nxt;
        s1_comp_nxt[3] = w12 + w21;
      end
    end else begin
      if (w00 < -w11) begin
        s1_t_nxt       = ONE_T - w00 - w11 + w22;
        s1_comp_nxt[0] = w01 - w10;
        s1_comp_nxt[1] = w20 + w02;
        s1_comp_nxt[2] = w12 + w21;
        s1_comp_nxt[3] = s1_t_nxt;
      end else begin
        s1_t_nxt       = ONE_T + w00 + w11 + w22;
        s1_comp_nxt[0] = s1_t_nxt;
        s1_comp_nxt[1] = w12 - w21;
        s1_comp_nxt[2] = w20 - w02;
        s1_comp_nxt[3] = w01 - w10;
      end
    end
  end

  always_ff @(posedge clk) begin
    s1_t_r     <= s1_t_nxt;
    s1_comp_r  <= s1_comp_nxt;
    s1_valid_r <= s0_valid_r;
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end
  end

  // drop a bad item to t = 1 with zero components so it scales to zero
  always_comb begin
    wide_t abs_v;
    s2_side_nxt.bad = !(s1_t_r > 0);
    for (int c = 0; c < NUM_COMP; c++) begin
      abs_v = s1_comp_r[c][TW-1] ? -s1_comp_r[c] : s1_comp_r[c];
      s2_side_nxt.neg[c] = s1_comp_r[c][TW-1] && !s2_side_nxt.bad;
      s2_side_nxt.mag[c] = s2_side_nxt.bad ? '0 : abs_v[MW-1:0];
    end
    s2_rad_nxt = s2_side_nxt.bad ? (RAD_W'(1) << FRAC_BITS)
                                 : (RAD_W'(s1_t_r[MW-1:0]) << FRAC_BITS);
  end

  always_ff @(posedge clk) begin
    s2_side_r  <= s2_side_nxt;
    s2_rad_r   <= s2_rad_nxt;
    s2_valid_r <= s1_valid_r;
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end
  end

  rmq_isqrt #(
    .RAD_W  (RAD_W),
    .SIDE_W ($bits(side_t))
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s2_valid_r),
    .in_rad    (s2_rad_r),
    .in_side   (s2_side_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side_bits)
  );

  assign sq_side = side_t'(sq_side_bits);

  rmq_div #(
    .FRAC_BITS (FRAC_BITS),
    .MAG_W     (MW),
    .ROOT_W    (ROOT_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_valid),
    .in_bad    (sq_side.bad),
    .in_mag    (sq_side.mag),
    .in_neg    (sq_side.neg),
    .in_root   (sq_root),
    .out_valid (out_valid),
    .out_bad   (out_bad_input),
    .out_q     (quat)
  );

  assign out_quat_w = quat[0];
  assign out_quat_x = quat[1];
  assign out_quat_y = quat[2];
  assign out_quat_z = quat[3];

`ifndef SYNTHESIS
  a_no_spurious_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result strobe without a matching input transaction");

  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("input transaction produced no result");

  a_bad_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bad_input) |->
      (out_quat_w == '0 && out_quat_x == '0 && out_quat_y == '0 && out_quat_z == '0))
    else $error("flagged result carries a nonzero quaternion");
`endif

endmodule

`default_nettype wire

// File: hdl/rmq_isqrt.sv
`default_nettype none

module rmq_isqrt #(
  parameter int RAD_W  = 32,
  parameter int SIDE_W = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [RAD_W-1:0]    in_rad,
  input  logic [SIDE_W-1:0]   in_side,
  output logic                out_valid,
  output logic [RAD_W/2-1:0]  out_root,
  output logic [SIDE_W-1:0]   out_side
);

  localparam int ROOT_W = RAD_W / 2;

  typedef struct packed {
    logic              valid;
    logic [RAD_W-1:0]  rem;
    logic [RAD_W-1:0]  res;
    logic [SIDE_W-1:0] side;
  } sq_stage_t;

  sq_stage_t stg_r [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam logic [RAD_W-1:0] BIT_V = RAD_W'(1) << (RAD_W - 2 - 2 * k);
    sq_stage_t        prv;
    sq_stage_t        stg_nxt;
    logic [RAD_W:0]   trial;
    logic             take;

    if (k == 0) begin : g_src
      assign prv = '{valid: in_valid, rem: in_rad, res: '0, side: in_side};
    end else begin : g_chain
      assign prv = stg_r[k-1];
    end

    always_comb begin
      trial   = {1'b0, prv.res} + {1'b0, BIT_V};
      take    = {1'b0, prv.rem} >= trial;
      stg_nxt = prv;
      if (take) begin
        stg_nxt.rem = prv.rem - trial[RAD_W-1:0];
        stg_nxt.res = (prv.res >> 1) + BIT_V;
      end else begin
        stg_nxt.res = prv.res >> 1;
      end
    end

    always_ff @(posedge clk) begin
      stg_r[k] <= stg_nxt;
      if (!rst_n) begin
        stg_r[k].valid <= 1'b0;
      end
    end
  end

  assign out_valid = stg_r[ROOT_W-1].valid;
  assign out_root  = stg_r[ROOT_W-1].res[ROOT_W-1:0];
  assign out_side  = stg_r[ROOT_W-1].side;

endmodule

`default_nettype wire

// File: hdl/rmq_div.sv
`default_nettype none

module rmq_div #(
  parameter int FRAC_BITS = 14,
  parameter int MAG_W     = 17,
  parameter int ROOT_W    = 16
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  input  logic                                          in_bad,
  input  logic [rmq_pkg::NUM_COMP-1:0][MAG_W-1:0]       in_mag,
  input  logic [rmq_pkg::NUM_COMP-1:0]                  in_neg,
  input  logic [ROOT_W-1:0]                             in_root,
  output logic                                          out_valid,
  output logic                                          out_bad,
  output rmq_pkg::elem_t [rmq_pkg::NUM_COMP-1:0]        out_q
);

  import rmq_pkg::*;

  localparam int DW = ROOT_W + 1;
  localparam int NW = MAG_W + FRAC_BITS + 1;
  localparam int QW = ((FRAC_BITS < ELEM_W - 1) ? FRAC_BITS : ELEM_W - 1) + 1;
  localparam int CW = (NW > DW + QW) ? NW : DW + QW;
  localparam int PW = FRAC_BITS + 1;
  localparam int XW = (PW > ELEM_W + 1) ? PW : ELEM_W + 1;

  localparam logic [XW-1:0] ONE_X   = XW'(1) << FRAC_BITS;
  localparam logic [XW-1:0] POS_LIM = XW'((2 ** (ELEM_W - 1)) - 1);
  localparam logic [XW-1:0] NEG_LIM = XW'(2 ** (ELEM_W - 1));

  typedef struct packed {
    logic                             valid;
    logic                             bad;
    logic [DW-1:0]                    den;
    logic [NUM_COMP-1:0]              neg;
    logic [NUM_COMP-1:0]              ovf;
    logic [NUM_COMP-1:0][CW-1:0]      rem;
    logic [NUM_COMP-1:0][QW-1:0]      quo;
  } div_stage_t;

  div_stage_t                      pre_r;
  div_stage_t                      pre_nxt;
  div_stage_t                      ovf_nxt;
  div_stage_t                      stg_r [QW+1];
  logic                            out_valid_r;
  logic                            out_bad_r;
  elem_t [NUM_COMP-1:0]            out_q_r;
  elem_t [NUM_COMP-1:0]            out_q_nxt;

  always_comb begin
    pre_nxt       = '0;
    pre_nxt.valid = in_valid;
    pre_nxt.bad   = in_bad;
    pre_nxt.den   = {in_root, 1'b0};
    pre_nxt.neg   = in_neg;
    for (int c = 0; c < NUM_COMP; c++) begin
      pre_nxt.rem[c] = (CW'(in_mag[c]) << FRAC_BITS) + CW'(in_root);
    end
  end

  always_ff @(posedge clk) begin
    pre_r <= pre_nxt;
    if (!rst_n) begin
      pre_r.valid <= 1'b0;
    end
  end

  always_comb begin
    ovf_nxt = pre_r;
    for (int c = 0; c < NUM_COMP; c++) begin
      ovf_nxt.ovf[c] = pre_r.rem[c] >= (CW'(pre_r.den) << QW);
    end
  end

  always_ff @(posedge clk) begin
    stg_r[0] <= ovf_nxt;
    if (!rst_n) begin
      stg_r[0].valid <= 1'b0;
    end
  end

  for (genvar j = 1; j <= QW; j++) begin : g_stage
    localparam int B = QW - j;
    div_stage_t          stg_nxt;
    logic [CW-1:0]       trial;

    always_comb begin
      stg_nxt = stg_r[j-1];
      trial   = CW'(stg_r[j-1].den) << B;
      for (int c = 0; c < NUM_COMP; c++) begin
        if (stg_r[j-1].rem[c] >= trial) begin
          stg_nxt.rem[c]    = stg_r[j-1].rem[c] - trial;
          stg_nxt.quo[c][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      stg_r[j] <= stg_nxt;
      if (!rst_n) begin
        stg_r[j].valid <= 1'b0;
      end
    end
  end

  always_comb begin
    logic [XW-1:0] pos_x;
    for (int c = 0; c < NUM_COMP; c++) begin
      pos_x = XW'(stg_r[QW].quo[c]);
      if (stg_r[QW].ovf[c] || pos_x > ONE_X) begin
        pos_x = ONE_X;
      end
      if (!stg_r[QW].neg[c]) begin
        out_q_nxt[c] = (pos_x > POS_LIM) ? elem_t'(POS_LIM[ELEM_W-1:0])
                                         : elem_t'(pos_x[ELEM_W-1:0]);
      end else begin
        out_q_nxt[c] = (pos_x > NEG_LIM) ? elem_t'(NEG_LIM[ELEM_W-1:0])
                                         : elem_t'(-pos_x[ELEM_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    out_q_r     <= out_q_nxt;
    out_bad_r   <= stg_r[QW].bad;
    out_valid_r <= stg_r[QW].valid;
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_bad   = out_bad_r;
  assign out_q     = out_q_r;

endmodule

`default_nettype wire

// File: dv/tb_rotation_matrix_to_quaternion_unit.sv
`timescale 1ns / 100ps

module tb_rotation_matrix_to_quaternion_unit;
  import rmq_pkg::*;

  localparam int     FRAC        = FRAC_BITS_DEF;
  localparam int     ONE         = 1 << FRAC;
  localparam int     LATENCY     = 37;
  localparam int     STALL_LIMIT = 2000;

  typedef logic [8:0][ELEM_W-1:0] mat_t;

  typedef struct packed {
    elem_t w;
    elem_t x;
    elem_t y;
    elem_t z;
    logic  bad;
  } quat_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  mat_t  in_mat = '0;
  logic  out_valid;
  elem_t out_quat_w;
  elem_t out_quat_x;
  elem_t out_quat_y;
  elem_t out_quat_z;
  logic  out_bad_input;

  quat_t expected_quats[$];
  int    errors = 0;
  int    stall_cycles = 0;
  int    idle_pct = 9;

  always #5 clk = ~clk;

  rotation_matrix_to_quaternion_unit DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_elem_r0c0 (in_mat[0]),
    .in_elem_r0c1 (in_mat[1]),
    .in_elem_r0c2 (in_mat[2]),
    .in_elem_r1c0 (in_mat[3]),
    .in_elem_r1c1 (in_mat[4]),
    .in_elem_r1c2 (in_mat[5]),
    .in_elem_r2c0 (in_mat[6]),
    .in_elem_r2c1 (in_mat[7]),
    .in_elem_r2c2 (in_mat[8]),
    .out_valid    (out_valid),
    .out_quat_w   (out_quat_w),
    .out_quat_x   (out_quat_x),
    .out_quat_y   (out_quat_y),
    .out_quat_z   (out_quat_z),
    .out_bad_input(out_bad_input)
  );

  function automatic longint floor_sqrt(longint v);
    longint root;
    longint trial;
    root = 0;
    for (int b = 24; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic quat_t predict_quaternion(mat_t m);
    longint a [9];
    longint comp [4];
    longint t;
    longint s;
    longint mag;
    longint q;
    elem_t  res [4];
    quat_t  r;
    for (int k = 0; k < 9; k++) a[k] = longint'($signed(m[k]));
    if (a[8] < 0) begin
      if (a[0] > a[4]) begin
        t = ONE + a[0] - a[4] - a[8];
        comp[0] = a[5] - a[7]; comp[1] = t; comp[2] = a[1] + a[3]; comp[3] = a[6] + a[2];
      end else begin
        t = ONE - a[0] + a[4] - a[8];
        comp[0] = a[6] - a[2]; comp[1] = a[1] + a[3]; comp[2] = t; comp[3] = a[5] + a[7];
      end
    end else begin
      if (a[0] < -a[4]) begin
        t = ONE - a[0] - a[4] + a[8];
        comp[0] = a[1] - a[3]; comp[1] = a[6] + a[2]; comp[2] = a[5] + a[7]; comp[3] = t;
      end else begin
        t = ONE + a[0] + a[4] + a[8];
        comp[0] = t; comp[1] = a[5] - a[7]; comp[2] = a[6] - a[2]; comp[3] = a[1] - a[3];
      end
    end
    if (t <= 0) begin
      r = '0;
      r.bad = 1'b1;
      return r;
    end
    s = floor_sqrt(t << FRAC);
    for (int k = 0; k < 4; k++) begin
      mag = (comp[k] < 0) ? -comp[k] : comp[k];
      q = ((mag << FRAC) + s) / (2 * s);
      if (q > ONE) q = ONE;
      if (comp[k] < 0) q = -q;
      res[k] = elem_t'(q);
    end
    r.w = res[0];
    r.x = res[1];
    r.y = res[2];
    r.z = res[3];
    r.bad = 1'b0;
    return r;
  endfunction

  function automatic mat_t mk(int e0, int e1, int e2, int e3, int e4,
                              int e5, int e6, int e7, int e8);
    mat_t m;
    m[0] = elem_t'(e0); m[1] = elem_t'(e1); m[2] = elem_t'(e2);
    m[3] = elem_t'(e3); m[4] = elem_t'(e4); m[5] = elem_t'(e5);
    m[6] = elem_t'(e6); m[7] = elem_t'(e7); m[8] = elem_t'(e8);
    return m;
  endfunction

  function automatic elem_t to_fixed(real v);
    int r;
    r = (v >= 0.0) ? $rtoi(v * 16384.0 + 0.5) : $rtoi(v * 16384.0 - 0.5);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return elem_t'(r);
  endfunction

  function automatic mat_t random_rotation();
    real  q [4];
    real  n;
    real  w, x, y, z;
    mat_t m;
    do begin
      for (int k = 0; k < 4; k++) begin
        q[k] = ($itor($urandom_range(0, 20000)) - 10000.0) / 10000.0;
        if ($urandom_range(0, 4) == 0) q[k] = 0.0;
      end
      n = q[0] * q[0] + q[1] * q[1] + q[2] * q[2] + q[3] * q[3];
    end while (n < 1.0e-4);
    n = $sqrt(n);
    w = q[0] / n; x = q[1] / n; y = q[2] / n; z = q[3] / n;
    m[0] = to_fixed(1.0 - 2.0 * (y * y + z * z));
    m[1] = to_fixed(2.0 * (x * y - w * z));
    m[2] = to_fixed(2.0 * (x * z + w * y));
    m[3] = to_fixed(2.0 * (x * y + w * z));
    m[4] = to_fixed(1.0 - 2.0 * (x * x + z * z));
    m[5] = to_fixed(2.0 * (y * z - w * x));
    m[6] = to_fixed(2.0 * (x * z - w * y));
    m[7] = to_fixed(2.0 * (y * z + w * x));
    m[8] = to_fixed(1.0 - 2.0 * (x * x + y * y));
    return m;
  endfunction

  function automatic mat_t random_matrix();
    mat_t m;
    for (int k = 0; k < 9; k++) m[k] = elem_t'(int'($urandom_range(0, 32768)) - 16384);
    return m;
  endfunction

  task automatic send_matrix(input mat_t m);
    start  <= 1'b1;
    in_mat <= m;
    do @(posedge clk); while (busy);
    expected_quats.push_back(predict_quaternion(m));
    if ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic test_directed();
    send_matrix(mk( ONE, 0, 0,  0,  ONE, 0,  0, 0,  ONE));
    send_matrix(mk( ONE, 0, 0,  0, -ONE, 0,  0, 0, -ONE));
    send_matrix(mk(-ONE, 0, 0,  0,  ONE, 0,  0, 0, -ONE));
    send_matrix(mk(-ONE, 0, 0,  0, -ONE, 0,  0, 0,  ONE));
    send_matrix(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(mk(ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE, ONE));
    send_matrix(mk(-ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE, -ONE));
    // components at full scale in both directions
    send_matrix(mk(-ONE, 0, 0,  0, ONE,  ONE,  0, -ONE, 0));
    send_matrix(mk(-ONE, 0, 0,  0, ONE, -ONE,  0,  ONE, 0));
    send_matrix(mk(-ONE, ONE, -ONE, -ONE, ONE, ONE, ONE, -ONE, 0));
    send_matrix(mk(-ONE, -ONE, ONE, ONE, ONE, -ONE, -ONE, ONE, 0));
    // branch boundaries: equal diagonal, sum of diagonal zero, sign of last element
    send_matrix(mk(5000, 1, 2, 3, 5000, 4, 5, 6, -1));
    send_matrix(mk(5001, 1, 2, 3, 5000, 4, 5, 6, -1));
    send_matrix(mk(-7000, 11, -12, 13, 7000, -14, 15, -16, 0));
    send_matrix(mk(-7001, 11, -12, 13, 7000, -14, 15, -16, 0));
    send_matrix(mk(ONE, ONE, ONE, -ONE, -ONE, -ONE, ONE, ONE, -ONE));
    send_matrix(mk(-ONE, ONE, -ONE, ONE, -ONE, ONE, -ONE, ONE, -ONE));
    send_matrix(mk(10922, -10923, 10922, -10923, 10922, -10923, 10922, -10923, 10922));
    send_matrix(mk(-10923, 10922, -10923, 10922, -10923, 10922, -10923, 10922, -10923));
    send_matrix(mk(1, -1, 1, -1, 1, -1, 1, -1, 1));
    send_matrix(mk(ONE - 1, 1 - ONE, 8191, -8192, ONE - 1, 16383, -1, 2, -ONE));
  endtask

  task automatic test_random_rotations(input int count, input int pct);
    idle_pct = pct;
    for (int i = 0; i < count; i++) send_matrix(random_rotation());
    idle_pct = 9;
  endtask

  task automatic test_arbitrary_matrices(input int count);
    for (int i = 0; i < count; i++) send_matrix(random_matrix());
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 20; i++) send_matrix(random_rotation());
    start <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk);
    for (int i = 0; i < 20; i++) send_matrix(random_rotation());
  endtask

  always @(posedge clk) begin
    quat_t exp_q;
    if (rst_n && out_valid) begin
      if (expected_quats.size() == 0) begin
        $error("unexpected transaction: w=%0d x=%0d y=%0d z=%0d bad=%0b",
               out_quat_w, out_quat_x, out_quat_y, out_quat_z, out_bad_input);
        errors++;
      end else begin
        exp_q = expected_quats.pop_front();
        if (out_quat_w !== exp_q.w) begin
          $error("quat_w: expected %0d, actual %0d", exp_q.w, out_quat_w);
          errors++;
        end
        if (out_quat_x !== exp_q.x) begin
          $error("quat_x: expected %0d, actual %0d", exp_q.x, out_quat_x);
          errors++;
        end
        if (out_quat_y !== exp_q.y) begin
          $error("quat_y: expected %0d, actual %0d", exp_q.y, out_quat_y);
          errors++;
        end
        if (out_quat_z !== exp_q.z) begin
          $error("quat_z: expected %0d, actual %0d", exp_q.z, out_quat_z);
          errors++;
        end
        if (out_bad_input !== exp_q.bad) begin
          $error("bad_input: expected %0b, actual %0b", exp_q.bad, out_bad_input);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_rotations(1200, 9);
    test_random_rotations(400, 0);
    test_drain_pause();
    test_arbitrary_matrices(290);
    start <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
